// ----- rtl/tle_pkg.sv -----
// shared types and constants for the toroidal life engine
// no dependencies; imported by toroidal_life_engine_unit
package tle_pkg;

  // grid limits and field widths
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int DIM_W      = 7;
  localparam int GEN_W      = 16;
  localparam int CFG_W      = 16;
  localparam int IDX_W      = 2;
  localparam int ADDR_W     = 1 + ROW_W + COL_W;
  localparam int MEM_DEPTH  = 2 ** ADDR_W;

  // rule constants
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // operation codes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_GENS   = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0]       op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cell_in;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic cell_out;
    logic run_done;
  } out_beat_t;

endpackage

// ----- rtl/toroidal_life_engine_unit.sv -----
// toroidal life engine top level: cell store, generation sequencer, result register
// depends on tle_pkg
//
// Conway life (B3/S23) on a wrapped grid held in two one-bit banks of one memory.
// A load beat gives no result. A read beat passes through S_RDWAIT and then presents
// its result, and a run beat passes through its cell passes and S_DONE and then
// presents its done result, each once the output register is free:
// every cell reads its nine neighbourhood cells one per cycle through the single
// memory read port, counted by one shared adder, and the new cell is written to the
// other bank in the last step of each cell pass; S_DONE loads the result register. in_ready
// is low while a read or run is in progress; a finished result sits in an output
// register so the next beat can be taken before it is collected.
module toroidal_life_engine_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tle_pkg::in_beat_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tle_pkg::out_beat_t     out_data,
  input  logic                   cfg_we,
  input  logic [tle_pkg::IDX_W-1:0] cfg_index,
  input  logic [tle_pkg::CFG_W-1:0] cfg_data
);
  import tle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RDWAIT = 4'b0010,
    S_RUN    = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t             state;
  logic [DIM_W-1:0]   grid_height;
  logic [DIM_W-1:0]   grid_width;
  logic [GEN_W-1:0]   generations;
  logic               cur;
  logic [ROW_W-1:0]   y;
  logic [COL_W-1:0]   x;
  logic [3:0]         k;
  logic [3:0]         cnt;
  logic               centre;
  logic [GEN_W-1:0]   gen_left;
  logic [ADDR_W-1:0]  rd_addr_q;
  logic               read_oor;
  logic               rd_data;

  logic               mem [MEM_DEPTH];

  logic [DIM_W-1:0]   h_eff, w_eff, h_m1, w_m1;
  logic [ROW_W-1:0]   y_up, y_dn, r_sel;
  logic [COL_W-1:0]   x_lf, x_rt, c_sel;
  logic               y_last, x_last;
  logic [1:0]         dy, dx;
  logic [ADDR_W-1:0]  rd_addr_c;
  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  logic               wdata;
  logic [3:0]         n9, n_nb;
  logic               alive;
  logic               in_beat, in_range, slot_free, res_load;

  // effective grid size: zero taken as one, clamp at the maximum
  always_comb begin
    if (grid_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (grid_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
    if (grid_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (grid_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
  end

  assign h_m1 = h_eff - DIM_W'(1);
  assign w_m1 = w_eff - DIM_W'(1);

  // wrapped neighbour rows and columns
  assign y_last = ({1'b0, y} + DIM_W'(1)) >= h_eff;
  assign x_last = ({1'b0, x} + DIM_W'(1)) >= w_eff;
  assign y_up   = (y == '0) ? h_m1[ROW_W-1:0] : y - ROW_W'(1);
  assign y_dn   = y_last ? '0 : y + ROW_W'(1);
  assign x_lf   = (x == '0) ? w_m1[COL_W-1:0] : x - COL_W'(1);
  assign x_rt   = x_last ? '0 : x + COL_W'(1);

  // step number to neighbourhood offset
  always_comb begin
    case (k)
      4'd0:    begin dy = 2'd0; dx = 2'd0; end
      4'd1:    begin dy = 2'd0; dx = 2'd1; end
      4'd2:    begin dy = 2'd0; dx = 2'd2; end
      4'd3:    begin dy = 2'd1; dx = 2'd0; end
      4'd4:    begin dy = 2'd1; dx = 2'd1; end
      4'd5:    begin dy = 2'd1; dx = 2'd2; end
      4'd6:    begin dy = 2'd2; dx = 2'd0; end
      4'd7:    begin dy = 2'd2; dx = 2'd1; end
      4'd8:    begin dy = 2'd2; dx = 2'd2; end
      default: begin dy = 2'd1; dx = 2'd1; end
    endcase
  end

  always_comb begin
    case (dy)
      2'd0:    r_sel = y_up;
      2'd2:    r_sel = y_dn;
      default: r_sel = y;
    endcase
    case (dx)
      2'd0:    c_sel = x_lf;
      2'd2:    c_sel = x_rt;
      default: c_sel = x;
    endcase
  end

  // handshake helpers
  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign in_range  = ({1'b0, in_data.row} < h_eff) && ({1'b0, in_data.col} < w_eff);
  assign slot_free = !out_valid || out_ready;

  // a new result takes the slot as the old one leaves
  assign res_load  = slot_free && ((state == S_RDWAIT) || (state == S_DONE));

  // shared count adder and the life rule
  assign n9    = cnt + {3'b000, rd_data};
  assign n_nb  = n9 - {3'b000, centre};
  assign alive = (n_nb == BIRTH_COUNT) || ((n_nb == SURVIVE_COUNT) && centre);

  // memory read address
  always_comb begin
    case (state)
      S_IDLE:  rd_addr_c = {cur, in_data.row, in_data.col};
      S_RUN:   rd_addr_c = {cur, r_sel, c_sel};
      default: rd_addr_c = rd_addr_q;
    endcase
  end

  // memory write port: loads when idle, new cells at the end of each cell pass
  always_comb begin
    mem_we = 1'b0;
    waddr  = {cur, in_data.row, in_data.col};
    wdata  = in_data.cell_in;
    if (in_beat && (in_data.op == OP_LOAD) && in_range) begin
      mem_we = 1'b1;
    end else if ((state == S_RUN) && (k == 4'd9)) begin
      mem_we = 1'b1;
      waddr  = {~cur, y, x};
      wdata  = alive;
    end
  end

  // cell store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr_c];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_height <= DIM_W'(MAX_HEIGHT);
      grid_width  <= DIM_W'(MAX_WIDTH);
      generations <= GEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT: grid_height <= cfg_data[DIM_W-1:0];
        REG_WIDTH:  grid_width  <= cfg_data[DIM_W-1:0];
        REG_GENS:   generations <= cfg_data[GEN_W-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
      cnt       <= '0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            rd_addr_q <= rd_addr_c;
            read_oor  <= !in_range;
            y         <= '0;
            x         <= '0;
            k         <= '0;
            cnt       <= '0;
            gen_left  <= generations;
            case (in_data.op)
              OP_READ: state <= S_RDWAIT;
              OP_RUN:  state <= (generations == '0) ? S_DONE : S_RUN;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RDWAIT: begin
          if (slot_free) begin
            out_data.cell_out <= read_oor ? 1'b0 : rd_data;
            out_data.run_done <= 1'b0;
            state             <= S_IDLE;
          end
        end
        S_RUN: begin
          // data of step k-1 arrives while step k is issued
          if (k == 4'd5) begin
            centre <= rd_data;
          end
          if (k == 4'd9) begin
            k   <= '0;
            cnt <= '0;
            if (!x_last) begin
              x <= x + COL_W'(1);
            end else begin
              x <= '0;
              if (!y_last) begin
                y <= y + ROW_W'(1);
              end else begin
                // generation complete
                y        <= '0;
                cur      <= ~cur;
                gen_left <= gen_left - GEN_W'(1);
                if (gen_left == GEN_W'(1)) begin
                  state <= S_DONE;
                end
              end
            end
          end else begin
            k <= k + 4'd1;
            if (k != 4'd0) begin
              cnt <= n9;
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_data.cell_out <= 1'b0;
            out_data.run_done <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // run writes never land in the bank being read
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && mem_we) |-> (waddr[ADDR_W-1] != rd_addr_c[ADDR_W-1]))
    else $error("run write hits the source bank");

  // a run with no generations reports at once
  a_zero_gen: assert property (@(posedge clk) disable iff (rst)
    (in_beat && in_data.op == OP_RUN && generations == '0) |=> (state == S_DONE))
    else $error("zero-generation run did not finish at once");

  // the current bank only flips while a run is going
  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (!$stable(cur) && !$past(rst)) |-> ($past(state) == S_RUN))
    else $error("current bank changed outside a run");
`endif

endmodule
